>>> hw/rtl/crrb_pkg.sv
package crrb_pkg;

    // Physical store depth; only the low 1024 entries are reachable
    localparam int STORE_DEPTH = 1024;
    localparam int RING_CAP    = (STORE_DEPTH < 1024) ? STORE_DEPTH : 1024;
    localparam int CAP_W       = $clog2(RING_CAP);

    localparam int POS_W  = 10;
    localparam int RING_W = 11;
    localparam int BYTE_W = 8;

    // Transaction kinds
    typedef enum logic [2:0] {
        KIND_RESERVE = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_PEEK    = 3'd2,
        KIND_READ    = 3'd3,
        KIND_CONSUME = 3'd4
    } kind_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_NO_DATA  = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_ORDER    = 3'd4
    } status_t;

    // Pointer state of the ring
    typedef struct packed {
        logic [POS_W-1:0] rd_ptr;
        logic [POS_W-1:0] wr_ptr;
        logic [POS_W-1:0] fill_cursor;
        logic [POS_W-1:0] bytes_left;
        logic [POS_W-1:0] wr_ptr_pend;
    } ptr_t;

    // Per-transaction outcome from the control logic
    typedef struct packed {
        ptr_t              ptr_next;
        status_t           status;
        logic [POS_W-1:0]  start_offset;
        logic              store_we;
        logic              store_re;
        logic [CAP_W-1:0]  store_addr;
        logic [POS_W-1:0]  used_count;
        logic [POS_W-1:0]  free_count;
    } step_t;

    // Readable bytes between read and write positions
    function automatic logic [POS_W-1:0] used_bytes(input logic [POS_W-1:0] wp,
                                                   input logic [POS_W-1:0] rp,
                                                   input logic [RING_W-1:0] ring);
        logic [RING_W-1:0] diff;
        if (wp >= rp) begin
            diff = {1'b0, wp} - {1'b0, rp};
        end else begin
            diff = ring - ({1'b0, rp} - {1'b0, wp});
        end
        return diff[POS_W-1:0];
    endfunction

    // Writable bytes, one slot kept empty
    function automatic logic [POS_W-1:0] free_bytes(input logic [POS_W-1:0] wp,
                                                   input logic [POS_W-1:0] rp,
                                                   input logic [RING_W-1:0] ring);
        logic [RING_W-1:0] diff;
        if (wp >= rp) begin
            diff = ring - ({1'b0, wp} - {1'b0, rp}) - RING_W'(1);
        end else begin
            diff = {1'b0, rp} - {1'b0, wp} - RING_W'(1);
        end
        return diff[POS_W-1:0];
    endfunction

endpackage

>>> hw/rtl/crrb_ctrl.sv
module crrb_ctrl (
    input  logic [2:0]                         kind,
    input  logic [crrb_pkg::POS_W-1:0]         record_length,
    input  logic [crrb_pkg::POS_W-1:0]         byte_offset,
    input  logic [crrb_pkg::RING_W-1:0]        ring_len,
    input  crrb_pkg::ptr_t                     ptr,
    output crrb_pkg::step_t                    step
);

    logic [crrb_pkg::RING_W-1:0] len_x;
    logic [crrb_pkg::RING_W-1:0] wp_room;
    logic [crrb_pkg::RING_W-1:0] rp_room;
    logic [crrb_pkg::RING_W-1:0] wp_sum;
    logic [crrb_pkg::RING_W-1:0] rp_sum;
    logic [crrb_pkg::POS_W-1:0]  free_now;
    logic [crrb_pkg::POS_W-1:0]  used_now;
    logic                        len_bad;

    // Shared length and room terms
    assign len_x    = {1'b0, record_length};
    assign len_bad  = (record_length == '0) || (len_x >= ring_len);
    assign wp_room  = ring_len - {1'b0, ptr.wr_ptr};
    assign rp_room  = ring_len - {1'b0, ptr.rd_ptr};
    assign wp_sum   = {1'b0, ptr.wr_ptr} + len_x;
    assign rp_sum   = {1'b0, ptr.rd_ptr} + len_x;
    assign free_now = crrb_pkg::free_bytes(ptr.wr_ptr, ptr.rd_ptr, ring_len);
    assign used_now = crrb_pkg::used_bytes(ptr.wr_ptr, ptr.rd_ptr, ring_len);

    // Decode one transaction into status, store access and next pointers
    always_comb begin
        step.ptr_next     = ptr;
        step.status       = crrb_pkg::ST_OK;
        step.start_offset = '0;
        step.store_we     = 1'b0;
        step.store_re     = 1'b0;
        step.store_addr   = '0;

        unique case (kind)
            crrb_pkg::KIND_RESERVE: begin
                if (ptr.bytes_left != '0) begin
                    step.status = crrb_pkg::ST_ORDER;
                end else if (len_bad) begin
                    step.status = crrb_pkg::ST_BAD_LEN;
                end else if (free_now < record_length) begin
                    step.status = crrb_pkg::ST_NO_SPACE;
                end else if (wp_room < len_x) begin
                    // record wraps to the start of the ring
                    if (ptr.rd_ptr <= record_length) begin
                        step.status = crrb_pkg::ST_NO_SPACE;
                    end else begin
                        step.start_offset           = '0;
                        step.ptr_next.wr_ptr_pend   = record_length;
                        step.ptr_next.fill_cursor   = '0;
                        step.ptr_next.bytes_left    = record_length;
                    end
                end else begin
                    step.start_offset            = ptr.wr_ptr;
                    step.ptr_next.wr_ptr_pend    = (wp_sum == ring_len) ? '0
                                                   : wp_sum[crrb_pkg::POS_W-1:0];
                    step.ptr_next.fill_cursor    = ptr.wr_ptr;
                    step.ptr_next.bytes_left     = record_length;
                end
            end
            crrb_pkg::KIND_DATA: begin
                if (ptr.bytes_left == '0 ||
                    {1'b0, ptr.fill_cursor} >= crrb_pkg::RING_W'(crrb_pkg::RING_CAP)) begin
                    step.status = crrb_pkg::ST_ORDER;
                end else begin
                    step.start_offset         = ptr.fill_cursor;
                    step.store_we             = 1'b1;
                    step.store_addr           = ptr.fill_cursor[crrb_pkg::CAP_W-1:0];
                    step.ptr_next.fill_cursor = ptr.fill_cursor + crrb_pkg::POS_W'(1);
                    step.ptr_next.bytes_left  = ptr.bytes_left - crrb_pkg::POS_W'(1);
                    // publish the record after its last byte
                    if (ptr.bytes_left == crrb_pkg::POS_W'(1)) begin
                        step.ptr_next.wr_ptr = ptr.wr_ptr_pend;
                    end
                end
            end
            crrb_pkg::KIND_PEEK: begin
                if (len_bad) begin
                    step.status = crrb_pkg::ST_BAD_LEN;
                end else if (used_now < record_length) begin
                    step.status = crrb_pkg::ST_NO_DATA;
                end else begin
                    step.start_offset = (rp_room < len_x) ? '0 : ptr.rd_ptr;
                end
            end
            crrb_pkg::KIND_READ: begin
                if ({1'b0, byte_offset} >= ring_len) begin
                    step.status = crrb_pkg::ST_BAD_LEN;
                end else begin
                    step.start_offset = byte_offset;
                    step.store_re     = 1'b1;
                    step.store_addr   = byte_offset[crrb_pkg::CAP_W-1:0];
                end
            end
            crrb_pkg::KIND_CONSUME: begin
                if (record_length == '0) begin
                    step.status = crrb_pkg::ST_OK;
                end else if (len_x >= ring_len) begin
                    step.status = crrb_pkg::ST_BAD_LEN;
                end else if (used_now < record_length) begin
                    step.status = crrb_pkg::ST_NO_DATA;
                end else if (rp_room < len_x) begin
                    step.ptr_next.rd_ptr = record_length;
                end else begin
                    step.ptr_next.rd_ptr = (rp_sum == ring_len) ? '0
                                           : rp_sum[crrb_pkg::POS_W-1:0];
                end
            end
            default: begin
                step.status = crrb_pkg::ST_ORDER;
            end
        endcase

        // Occupancy after the transaction
        step.used_count = crrb_pkg::used_bytes(step.ptr_next.wr_ptr,
                                               step.ptr_next.rd_ptr, ring_len);
        step.free_count = crrb_pkg::free_bytes(step.ptr_next.wr_ptr,
                                               step.ptr_next.rd_ptr, ring_len);
    end

endmodule

>>> hw/rtl/contiguous_record_ring_buffer_unit.sv
// Ring buffer of variable-length records, each kept contiguous in a byte store.
// Every input transaction (reserve, data byte, peek, read byte, consume) yields
// exactly one result with a status and the used/free byte counts after it.
// One transaction is taken per clock and its result is valid the cycle after:
// the decision logic sits between the input handshake and the result register,
// and the byte store is a single port memory touched at most once per
// transaction with a registered read. A result still waiting on m_tready holds
// off the next transaction, so the rate drops below one per clock only when the
// receiver stalls. A write on the cfg channel sets the ring size (clamped to
// 2..1024) and empties the ring; do it only while idle.
module contiguous_record_ring_buffer_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: ring size
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,       // [10:0] ring_size

    // Input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,        // [2:0] kind
    input  logic [31:0] s_tdata,        // [9:0] record_length, [17:10] data_byte,
                                        // [27:18] byte_offset, [31:28] zero

    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata         // [2:0] status, [12:3] start_offset,
                                        // [20:13] read_value, [30:21] used_count,
                                        // [40:31] free_count, [47:41] zero
);

    localparam int POS_W  = crrb_pkg::POS_W;
    localparam int RING_W = crrb_pkg::RING_W;
    localparam int BYTE_W = crrb_pkg::BYTE_W;

    logic [BYTE_W-1:0] store_mem [crrb_pkg::RING_CAP];

    logic [RING_W-1:0] ring_len_reg;
    crrb_pkg::ptr_t    ptr_reg;
    crrb_pkg::step_t   step;

    logic              m_valid_reg;
    logic [2:0]        status_reg;
    logic [POS_W-1:0]  start_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic [POS_W-1:0]  used_reg;
    logic [POS_W-1:0]  free_reg;

    logic              in_xact;
    logic              cfg_xact;
    logic [RING_W-1:0] ring_clamped;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign cfg_xact  = cfg_valid & cfg_ready;
    assign s_tready  = ~m_valid_reg | m_tready;
    assign in_xact   = s_tvalid & s_tready;

    // Clamp the requested ring size into the usable range
    always_comb begin
        priority if (cfg_data < RING_W'(2)) begin
            ring_clamped = RING_W'(2);
        end else if (cfg_data > RING_W'(crrb_pkg::RING_CAP)) begin
            ring_clamped = RING_W'(crrb_pkg::RING_CAP);
        end else begin
            ring_clamped = cfg_data;
        end
    end

    // Transaction decode
    crrb_ctrl u_ctrl (
        .kind          (s_tuser),
        .record_length (s_tdata[9:0]),
        .byte_offset   (s_tdata[27:18]),
        .ring_len      (ring_len_reg),
        .ptr           (ptr_reg),
        .step          (step)
    );

    // Ring size and pointer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_len_reg <= RING_W'(crrb_pkg::RING_CAP);
            ptr_reg      <= '0;
        end else if (cfg_xact) begin
            ring_len_reg <= ring_clamped;
            ptr_reg      <= '0;
        end else if (in_xact) begin
            ptr_reg      <= step.ptr_next;
        end
    end

    // Byte store write
    always_ff @(posedge aclk) begin
        if (in_xact && step.store_we) begin
            store_mem[step.store_addr] <= s_tdata[17:10];
        end
    end

    // Byte store read, registered straight into the result
    always_ff @(posedge aclk) begin
        if (in_xact) begin
            if (step.store_re) begin
                rdata_reg <= store_mem[step.store_addr];
            end else begin
                rdata_reg <= '0;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xact) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xact) begin
            status_reg <= step.status;
            start_reg  <= step.start_offset;
            used_reg   <= step.used_count;
            free_reg   <= step.free_count;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, free_reg, used_reg, rdata_reg, start_reg, status_reg};

endmodule
